// ===== src/msdac_pkg.sv =====
// Shared types, constants and the sine table for the microstep DAC serializer.
// No dependencies; every other file in src refers to this package by scoped names.
package msdac_pkg;

    localparam int FRAME_BITS   = 16;
    localparam int IDX_W        = 4;
    localparam int BYTE_W       = 8;
    localparam int ENTRY_W      = 14;
    localparam int PROD_W       = ENTRY_W + BYTE_W;
    localparam int AMP_W        = 10;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [AMP_W-1:0]  AMP_RESET   = 10'd100;
    localparam logic [BYTE_W-1:0] SCALE_RESET = 8'd42;
    localparam logic [BYTE_W-1:0] SCALE_MAX   = 8'd255;

    // floor(y / 40) = (y * 52429) >> 21, exact for y < 2^15
    localparam int SCALE_PROD_W = 31;
    localparam int SCALE_SHIFT  = 21;
    localparam logic [15:0] SCALE_RECIP = 16'd52429;

    // floor(x / 10000) = (x * 6871948) >> 36, exact for x < 2^22
    localparam int UNIT_PROD_W = 45;
    localparam int UNIT_SHIFT  = 36;
    localparam logic [22:0] UNIT_RECIP = 23'd6871948;

    localparam logic [IDX_W-1:0] PEAK_IDX   = 4'd8;
    localparam logic [IDX_W-1:0] COS_OFFSET = 4'd8;
    localparam logic [IDX_W-1:0] LAST_BIT   = 4'd15;

    typedef enum logic [1:0] {
        OP_MICROSTEP = 2'd0,
        OP_RAW_PAIR  = 2'd1,
        OP_FULL      = 2'd2
    } t_op;

    typedef struct packed {
        logic                  valid;
        logic [FRAME_BITS-1:0] word;
    } t_word_xfer;

    // Half-wave sine in units of 1/10000; cosine is the same table offset by 8.
    function automatic logic [ENTRY_W-1:0] sine_entry(input logic [IDX_W-1:0] idx);
        logic [ENTRY_W-1:0] v;
        case (idx)
            4'd0:    v = 14'd0;
            4'd1:    v = 14'd1951;
            4'd2:    v = 14'd3827;
            4'd3:    v = 14'd5556;
            4'd4:    v = 14'd7071;
            4'd5:    v = 14'd8315;
            4'd6:    v = 14'd9239;
            4'd7:    v = 14'd9808;
            4'd8:    v = 14'd10000;
            4'd9:    v = 14'd9808;
            4'd10:   v = 14'd9239;
            4'd11:   v = 14'd8315;
            4'd12:   v = 14'd7071;
            4'd13:   v = 14'd5556;
            4'd14:   v = 14'd3827;
            4'd15:   v = 14'd1951;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/msdac_front.sv =====
// Front end: amplitude register, request decode and three-stage word builder.
// Depends on msdac_pkg; feeds msdac_queue.
module msdac_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [msdac_pkg::AMP_W-1:0]         i_cfg_amplitude,
    input  logic                                i_push,
    input  logic [1:0]                          i_operation,
    input  logic [7:0]                          i_step,
    input  logic [7:0]                          i_raw_a,
    input  logic [7:0]                          i_raw_b,
    input  logic                                i_q_full,
    output logic                                o_full,
    output msdac_pkg::t_word_xfer               o_wr
);

    logic [msdac_pkg::AMP_W-1:0]  r_amplitude;
    logic [msdac_pkg::BYTE_W-1:0] r_scale, n_scale;
    logic [14:0]                  scale_num;
    logic [msdac_pkg::SCALE_PROD_W-1:0] scale_prod;

    logic                             en;
    logic                             accept;

    // stage 1: decoded request
    logic                             r_v1, n_v1;
    logic                             r_raw1, n_raw1;
    logic [msdac_pkg::IDX_W-1:0]      r_ia1, n_ia1, r_ib1, n_ib1;
    logic [msdac_pkg::FRAME_BITS-1:0] r_rw1, n_rw1;

    // stage 2: entry * scale
    logic                             r_v2, r_raw2;
    logic [msdac_pkg::PROD_W-1:0]     r_pa2, r_pb2;
    logic [msdac_pkg::FRAME_BITS-1:0] r_rw2;

    // stage 3: finished word
    logic                             r_v3;
    logic [msdac_pkg::FRAME_BITS-1:0] r_word3;

    logic [msdac_pkg::UNIT_PROD_W-1:0] qa_prod, qb_prod;

    assign en     = !(r_v3 && i_q_full);
    assign o_full = !en;
    assign accept = i_push && en;

    // scale = min(255, floor(amplitude * 17 / 40))
    assign scale_num  = {r_amplitude, 4'b0} + 15'(r_amplitude);
    assign scale_prod = msdac_pkg::SCALE_PROD_W'(scale_num)
                        * msdac_pkg::SCALE_PROD_W'(msdac_pkg::SCALE_RECIP);

    always_comb begin
        if (scale_prod[msdac_pkg::SCALE_PROD_W-1:msdac_pkg::SCALE_SHIFT] > 10'(msdac_pkg::SCALE_MAX)) begin
            n_scale = msdac_pkg::SCALE_MAX;
        end else begin
            n_scale = scale_prod[msdac_pkg::SCALE_SHIFT +: msdac_pkg::BYTE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= msdac_pkg::AMP_RESET;
            r_scale     <= msdac_pkg::SCALE_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_amplitude <= i_cfg_amplitude;
            end
            r_scale <= n_scale;
        end
    end

    // Decode: table index pair or raw bytes; unused code drops the request.
    always_comb begin
        n_v1   = accept;
        n_raw1 = 1'b0;
        n_ia1  = i_step[3:0];
        n_ib1  = i_step[3:0] + msdac_pkg::COS_OFFSET;
        n_rw1  = {i_raw_a, i_raw_b};
        case (i_operation)
            msdac_pkg::OP_MICROSTEP: begin
            end
            msdac_pkg::OP_RAW_PAIR: begin
                n_raw1 = 1'b1;
            end
            msdac_pkg::OP_FULL: begin
                n_ia1 = msdac_pkg::PEAK_IDX;
                n_ib1 = msdac_pkg::PEAK_IDX;
            end
            default: begin
                n_v1 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= n_v1;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign qa_prod = msdac_pkg::UNIT_PROD_W'(r_pa2) * msdac_pkg::UNIT_PROD_W'(msdac_pkg::UNIT_RECIP);
    assign qb_prod = msdac_pkg::UNIT_PROD_W'(r_pb2) * msdac_pkg::UNIT_PROD_W'(msdac_pkg::UNIT_RECIP);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_raw1 <= n_raw1;
            r_ia1  <= n_ia1;
            r_ib1  <= n_ib1;
            r_rw1  <= n_rw1;

            r_raw2 <= r_raw1;
            r_rw2  <= r_rw1;
            r_pa2  <= msdac_pkg::PROD_W'(msdac_pkg::sine_entry(r_ia1)) * msdac_pkg::PROD_W'(r_scale);
            r_pb2  <= msdac_pkg::PROD_W'(msdac_pkg::sine_entry(r_ib1)) * msdac_pkg::PROD_W'(r_scale);

            if (r_raw2) begin
                r_word3 <= r_rw2;
            end else begin
                r_word3 <= {qa_prod[msdac_pkg::UNIT_SHIFT +: msdac_pkg::BYTE_W],
                            qb_prod[msdac_pkg::UNIT_SHIFT +: msdac_pkg::BYTE_W]};
            end
        end
    end

    assign o_wr.valid = r_v3 && !i_q_full;
    assign o_wr.word  = r_word3;

endmodule

// ===== src/msdac_queue.sv =====
// Small word queue between the word builder and the serializer.
// Depends on msdac_pkg for the transfer struct.
module msdac_queue #(
    parameter int DEPTH = msdac_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  msdac_pkg::t_word_xfer i_wr,
    output logic                  o_full,
    input  logic                  i_rd,
    output msdac_pkg::t_word_xfer o_rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [msdac_pkg::FRAME_BITS-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign wr_en      = i_wr.valid && !o_full;
    assign rd_en      = i_rd && (r_cnt != '0);
    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.word  = r_mem[r_rp];

    always_comb begin
        n_wp  = (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
        n_rp  = (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
        n_cnt = r_cnt + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= n_wp;
            end
            if (rd_en) begin
                r_rp <= n_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr.word;
        end
    end

endmodule

// ===== src/msdac_back.sv =====
// Back end: shifts one queued word out MSB first, one bit per transaction.
// Depends on msdac_pkg; reads from msdac_queue.
module msdac_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  msdac_pkg::t_word_xfer               i_q,
    output logic                                o_q_rd,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic                                o_data_bit,
    output logic [msdac_pkg::IDX_W-1:0]         o_bit_index,
    output logic [msdac_pkg::FRAME_BITS-1:0]    o_frame_word,
    output logic                                o_last
);

    logic                             r_busy;
    logic [msdac_pkg::IDX_W-1:0]      r_idx;
    logic [msdac_pkg::FRAME_BITS-1:0] r_word;
    logic                             advance, done;

    assign advance = r_busy && i_pop;
    assign done    = advance && (r_idx == msdac_pkg::LAST_BIT);
    assign o_q_rd  = i_q.valid && (!r_busy || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_q_rd) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (advance) begin
            r_idx <= r_idx + msdac_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_word <= i_q.word;
        end
    end

    assign o_empty      = !r_busy;
    assign o_data_bit   = r_word[~r_idx];
    assign o_bit_index  = r_idx;
    assign o_frame_word = r_word;
    assign o_last       = (r_idx == msdac_pkg::LAST_BIT);

endmodule

// ===== src/microstep_sine_cosine_dac_serializer.sv =====
// Microstep sine/cosine DAC serializer, top level; depends on msdac_pkg, msdac_front,
// msdac_queue, msdac_back.
// The first bit of a word reaches the result ports from the accepting edge through builder
// stages 2 and 3, the queue write and the serializer load.
// Throughput: one word per 16 result transactions, set by the one-bit-per-pop shifter;
// the front keeps accepting until the queue backs up. Reset: amplitude 100, all empty.
module microstep_sine_cosine_dac_serializer #(
    parameter int QUEUE_DEPTH = msdac_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // amplitude register write transaction
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [msdac_pkg::AMP_W-1:0]         i_cfg_amplitude,

    // request side
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          i_operation,
    input  logic [7:0]                          i_step,
    input  logic [7:0]                          i_raw_a,
    input  logic [7:0]                          i_raw_b,

    // serial bit side
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_data_bit,
    output logic [3:0]                          o_bit_index,
    output logic [15:0]                         o_frame_word,
    output logic                                o_last
);

    msdac_pkg::t_word_xfer wr_xfer;
    msdac_pkg::t_word_xfer rd_xfer;
    logic                  q_full;
    logic                  q_rd;

    // Register write is always taken; the scale byte is registered from it in the next cycle.
    assign o_cfg_ready = 1'b1;

    // Front: decode, entry * scale, divide by 10000 via reciprocal, pack A:B.
    msdac_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_amplitude (i_cfg_amplitude),
        .i_push          (push),
        .i_operation     (i_operation),
        .i_step          (i_step),
        .i_raw_a         (i_raw_a),
        .i_raw_b         (i_raw_b),
        .i_q_full        (q_full),
        .o_full          (full),
        .o_wr            (wr_xfer)
    );

    // Decoupling queue of finished words.
    msdac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr_xfer),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rd    (rd_xfer)
    );

    // Back: MSB-first shifter; the next word loads on the pop of the last bit.
    msdac_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q          (rd_xfer),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_data_bit   (o_data_bit),
        .o_bit_index  (o_bit_index),
        .o_frame_word (o_frame_word),
        .o_last       (o_last)
    );

endmodule

// ===== verif/tb_microstep_sine_cosine_dac_serializer.sv =====
// Testbench for the microstep sine/cosine DAC serializer: request queue in, serial bits out.
// Predicts every serial bit from its own amplitude copy and sine table, checks each popped bit.
// Depends on msdac_pkg and microstep_sine_cosine_dac_serializer.
`timescale 1ns / 1ps

module tb_microstep_sine_cosine_dac_serializer;

    // Operation code 3 has no meaning; the block drops it without output.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int PHASE_ITEMS  = 41;      // counted requests per random phase
    localparam int DRAIN_CYCLES = 12;      // outlasts the front pipeline, lets dropped requests clear
    localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run

    // Half-wave sine in 1/10000 units; cosine is the same table shifted by 8.
    localparam int SINE_PT [16] = '{
        0, 1951, 3827, 5556, 7071, 8315, 9239, 9808,
        10000, 9808, 9239, 8315, 7071, 5556, 3827, 1951
    };

    typedef enum {RX_STREAM, RX_LIGHT, RX_HEAVY} t_rx_mode;

    // One serial-bit transaction as seen on the result ports.
    typedef struct packed {
        logic        data_bit;
        logic [3:0]  bit_index;
        logic [15:0] frame_word;
        logic        last;
    } t_serial_bit;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [msdac_pkg::AMP_W-1:0]   i_cfg_amplitude;
    logic                          push;
    logic                          full;
    logic [1:0]                    i_operation;
    logic [7:0]                    i_step;
    logic [7:0]                    i_raw_a;
    logic [7:0]                    i_raw_b;
    logic                          empty;
    logic                          pop = 1'b0;
    logic                          o_data_bit;
    logic [3:0]                    o_bit_index;
    logic [15:0]                   o_frame_word;
    logic                          o_last;

    // Model state: the amplitude register as the block should hold it.
    logic [msdac_pkg::AMP_W-1:0]   amplitude_shadow;
    t_serial_bit                   pending_bits[$];    // expected serial bits, oldest first
    int                            error_count = 0;
    int                            cycle_count = 0;
    t_rx_mode                      rx_mode = RX_LIGHT;
    logic [7:0]                    stall_mask = 8'h00;
    logic [2:0]                    stall_slot = 3'd0;

    microstep_sine_cosine_dac_serializer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_amplitude (i_cfg_amplitude),
        .push            (push),
        .full            (full),
        .i_operation     (i_operation),
        .i_step          (i_step),
        .i_raw_a         (i_raw_a),
        .i_raw_b         (i_raw_b),
        .empty           (empty),
        .pop             (pop),
        .o_data_bit      (o_data_bit),
        .o_bit_index     (o_bit_index),
        .o_frame_word    (o_frame_word),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or a lost frame ends here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_microstep_sine_cosine_dac_serializer: errors");
        $finish;
    end

    // DAC word for one request: phase A in the high byte, phase B in the low byte.
    // Scale byte = floor(amp * 17 / 40) clipped to 255; entries truncate after / 10000.
    function automatic logic [15:0] dac_word(logic [1:0] op, logic [7:0] step,
                                             logic [7:0] ra, logic [7:0] rb,
                                             logic [msdac_pkg::AMP_W-1:0] amp);
        int         scale;
        logic [7:0] phase_a;
        logic [7:0] phase_b;
        scale = (int'(amp) * 17) / 40;
        if (scale > 255) scale = 255;
        case (op)
            msdac_pkg::OP_MICROSTEP: begin
                phase_a = 8'((SINE_PT[step[3:0]] * scale) / 10000);
                phase_b = 8'((SINE_PT[4'(step[3:0] + 4'd8)] * scale) / 10000);
            end
            msdac_pkg::OP_RAW_PAIR: begin
                phase_a = ra;
                phase_b = rb;
            end
            default: begin
                // full scale: sine peak and cosine peak are both the 10000 entry
                phase_a = 8'((SINE_PT[8] * scale) / 10000);
                phase_b = phase_a;
            end
        endcase
        return {phase_a, phase_b};
    endfunction

    function automatic void flag_mismatch(string what, t_serial_bit want, t_serial_bit got);
        error_count++;
        if (error_count <= 10)
            $display({"%0t %s: want bit=%0d idx=%0d word=%04h last=%0d, ",
                      "got bit=%0d idx=%0d word=%04h last=%0d"},
                     $realtime, what, want.data_bit, want.bit_index, want.frame_word,
                     want.last, got.data_bit, got.bit_index, got.frame_word, got.last);
    endfunction

    // Presents one request from a falling edge and holds it until the block accepts it.
    // Leaves push high so back-to-back requests need no extra assignment.
    task automatic send_request(logic [1:0] op, logic [7:0] step, logic [7:0] ra,
                                logic [7:0] rb);
        logic [15:0] word;
        i_operation = op;
        i_step      = step;
        i_raw_a     = ra;
        i_raw_b     = rb;
        push        = 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        // accepted at this edge: queue up the sixteen bits, MSB first
        if (op != OP_UNUSED) begin
            word = dac_word(op, step, ra, rb, amplitude_shadow);
            for (int k = 0; k < msdac_pkg::FRAME_BITS; k++)
                pending_bits.push_back('{word[msdac_pkg::FRAME_BITS-1-k], 4'(k), word,
                                         k == msdac_pkg::FRAME_BITS - 1});
        end
        @(negedge i_clk);
    endtask

    // Block is idle once every bit has drained and any dropped request has left the pipe.
    task automatic wait_for_idle();
        push = 1'b0;
        while (pending_bits.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_amplitude(logic [msdac_pkg::AMP_W-1:0] amp);
        i_cfg_amplitude = amp;
        i_cfg_valid     = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        amplitude_shadow = amp;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Receiver: pop follows an 8-bit stall mask, redrawn each time its slot counter wraps.
    // Light mode stalls about a quarter of the time, heavy about three quarters.
    always @(negedge i_clk) begin
        if (stall_slot == 3'd0) begin
            case (rx_mode)
                RX_STREAM: stall_mask = 8'h00;
                RX_LIGHT:  stall_mask = 8'($urandom & $urandom);
                default:   stall_mask = 8'($urandom | $urandom);
            endcase
        end
        pop <= !stall_mask[stall_slot];
        stall_slot = stall_slot + 3'd1;
    end

    // Checker: every popped transaction against the oldest expected bit.
    always @(posedge i_clk) begin : bit_checker
        t_serial_bit got;
        t_serial_bit want;
        if (i_rst_n && pop && !empty) begin
            got = '{o_data_bit, o_bit_index, o_frame_word, o_last};
            if (pending_bits.size() == 0) begin
                flag_mismatch("unexpected bit", '0, got);
            end else begin
                want = pending_bits.pop_front();
                if (got !== want) flag_mismatch("bit mismatch", want, got);
            end
        end
    end

    // Reset amplitude (100 -> scale 42): full-scale pair and all sixteen table points.
    // Step k*17 puts k in both nibbles, so the ignored high bits toggle too.
    task automatic test_reset_amplitude();
        send_request(msdac_pkg::OP_FULL, 8'h00, 8'h00, 8'h00);
        for (int k = 0; k < 16; k++)
            send_request(msdac_pkg::OP_MICROSTEP, 8'(k * 17), 8'($urandom), 8'($urandom));
        wait_for_idle();
    endtask

    // Raw byte extremes and alternating patterns, then an unused code that must vanish.
    task automatic test_raw_and_unused();
        send_request(msdac_pkg::OP_RAW_PAIR, 8'h00, 8'h00, 8'h00);
        send_request(msdac_pkg::OP_RAW_PAIR, 8'hFF, 8'hFF, 8'hFF);
        send_request(msdac_pkg::OP_RAW_PAIR, 8'h5A, 8'hA5, 8'h5A);
        send_request(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
        wait_for_idle();
    endtask

    // Zero amplitude gives all-zero words; 1023 saturates the scale at 255.
    task automatic test_amplitude_extremes();
        write_amplitude('0);
        send_request(msdac_pkg::OP_FULL, 8'h00, 8'h00, 8'h00);
        send_request(msdac_pkg::OP_MICROSTEP, 8'h03, 8'h00, 8'h00);
        wait_for_idle();
        write_amplitude('1);
        send_request(msdac_pkg::OP_FULL, 8'h00, 8'h00, 8'h00);
        send_request(msdac_pkg::OP_MICROSTEP, 8'hF8, 8'h00, 8'h00);
        wait_for_idle();
    endtask

    // One random phase: set amplitude while idle, then bursts of mixed requests.
    // Half microstep, a quarter raw pairs, the rest mostly full scale with a few dropped codes.
    task automatic test_random_phase(logic [msdac_pkg::AMP_W-1:0] amp, int gap_max,
                                     t_rx_mode mode);
        int         counted;
        int         burst;
        int         gap;
        int         pick;
        logic [1:0] op;
        rx_mode = mode;
        write_amplitude(amp);
        counted = 0;
        burst   = 0;
        while (counted < PHASE_ITEMS) begin
            if (burst == 0) begin
                gap = $urandom_range(gap_max);
                if (gap > 0) begin
                    push = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst = $urandom_range(12, 1);
            end
            pick = $urandom_range(99);
            if (pick < 50)      op = msdac_pkg::OP_MICROSTEP;
            else if (pick < 75) op = msdac_pkg::OP_RAW_PAIR;
            else if (pick < 92) op = msdac_pkg::OP_FULL;
            else                op = OP_UNUSED;
            send_request(op, 8'($urandom), 8'($urandom), 8'($urandom));
            burst--;
            if (op != OP_UNUSED) counted++;
        end
        wait_for_idle();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_amplitude  = '0;
        push             = 1'b0;
        i_operation      = msdac_pkg::OP_MICROSTEP;
        i_step           = '0;
        i_raw_a          = '0;
        i_raw_b          = '0;
        amplitude_shadow = 10'd100;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_amplitude();
        test_raw_and_unused();
        test_amplitude_extremes();

        // Amplitudes around the saturation knee (599 -> 254, 600 -> 255) plus randoms;
        // sender gaps and receiver stalls rotate across the amplitudes.
        test_random_phase(10'd0,    0,  RX_LIGHT);
        test_random_phase(10'd1,    3,  RX_HEAVY);
        test_random_phase(10'd599,  10, RX_STREAM);
        test_random_phase(10'd600,  0,  RX_HEAVY);
        test_random_phase(10'd601,  3,  RX_STREAM);
        test_random_phase(10'd1023, 10, RX_LIGHT);
        test_random_phase(10'($urandom_range(600)),  3,  RX_LIGHT);
        test_random_phase(10'($urandom_range(1023)), 0,  RX_STREAM);

        if (error_count == 0)
            $display("tb_microstep_sine_cosine_dac_serializer: clean");
        else
            $display("tb_microstep_sine_cosine_dac_serializer: errors");
        $finish;
    end

endmodule
